// ===== rtl/tlsp_pkg.sv =====
package tlsp_pkg;

	localparam int UNRSV_WORDS = 8;

	localparam logic [15:0] ST_LINK_TYPE   = 16'd1;
	localparam logic [15:0] ST_LINK_ID     = 16'd2;
	localparam logic [15:0] ST_LOCAL_ADDR  = 16'd3;
	localparam logic [15:0] ST_REMOTE_ADDR = 16'd4;
	localparam logic [15:0] ST_METRIC      = 16'd5;
	localparam logic [15:0] ST_MAX_BW      = 16'd6;
	localparam logic [15:0] ST_MAX_RSV_BW  = 16'd7;
	localparam logic [15:0] ST_UNRSV_BW    = 16'd8;
	localparam logic [15:0] ST_ADMIN_GROUP = 16'd9;

	localparam logic [3:0] FC_LINK_TYPE   = 4'd0;
	localparam logic [3:0] FC_LINK_ID     = 4'd1;
	localparam logic [3:0] FC_LOCAL_ADDR  = 4'd2;
	localparam logic [3:0] FC_REMOTE_ADDR = 4'd3;
	localparam logic [3:0] FC_METRIC      = 4'd4;
	localparam logic [3:0] FC_MAX_BW      = 4'd5;
	localparam logic [3:0] FC_MAX_RSV_BW  = 4'd6;
	localparam logic [3:0] FC_UNRSV_BW    = 4'd7;
	localparam logic [3:0] FC_ADMIN_GROUP = 4'd8;
	localparam logic [3:0] FC_END         = 4'd9;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_t;

	typedef struct packed {
		logic [3:0]  field_code;
		logic [2:0]  slot_index;
		logic [31:0] field_value;
		logic        parse_ok;
		logic        last_result;
	} res_t;

	typedef struct packed {
		logic push_a;
		logic push_b;
		res_t res_a;
		res_t res_b;
	} push_t;

endpackage

// ===== rtl/tlsp_stream_if.sv =====
interface tlsp_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/tlsp_core.sv =====
module tlsp_core #(
	parameter int ADDR_SLOTS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            acc,
	input  tlsp_pkg::byte_t in_byte,
	output tlsp_pkg::push_t push
);
	import tlsp_pkg::*;

	localparam int FILL_W = $clog2(ADDR_SLOTS + 1);

	logic [1:0]        hdr_pos_q, hdr_pos_n;
	logic              in_value_q, in_value_n;
	logic [15:0]       voff_q, voff_n;
	logic [15:0]       type_q, type_n;
	logic [15:0]       len_q, len_n;
	logic [31:0]       shift_q, shift_n;
	logic [3:0]        wc_q, wc_n;
	logic [FILL_W-1:0] lfill_q, lfill_n;
	logic [FILL_W-1:0] rfill_q, rfill_n;
	logic              seen_type_q, seen_type_n;
	logic              seen_id_q, seen_id_n;

	logic        fld_v;
	res_t        fld;
	res_t        end_res;
	logic [16:0] padded;
	logic [16:0] voff_inc;
	logic [7:0]  b;

	assign b        = in_byte.data_byte;
	assign padded   = ({1'b0, len_q} + 17'd3) & ~17'd3;
	assign voff_inc = {1'b0, voff_q} + 17'd1;

	always_comb begin
		hdr_pos_n   = hdr_pos_q;
		in_value_n  = in_value_q;
		voff_n      = voff_q;
		type_n      = type_q;
		len_n       = len_q;
		shift_n     = shift_q;
		wc_n        = wc_q;
		lfill_n     = lfill_q;
		rfill_n     = rfill_q;
		seen_type_n = seen_type_q;
		seen_id_n   = seen_id_q;
		fld_v       = 1'b0;
		fld         = '0;

		if (!in_value_q) begin
			unique case (hdr_pos_q)
				2'd0: type_n = {b, 8'h00};
				2'd1: type_n = {type_q[15:8], b};
				2'd2: len_n  = {b, 8'h00};
				2'd3: len_n  = {len_q[15:8], b};
			endcase
			if (hdr_pos_q == 2'd3) begin
				shift_n    = '0;
				wc_n       = '0;
				voff_n     = '0;
				hdr_pos_n  = 2'd0;
				in_value_n = (len_n != 16'd0);
			end else begin
				hdr_pos_n = hdr_pos_q + 2'd1;
			end
		end else begin
			shift_n = {shift_q[23:0], b};
			// length is nonzero here, so the link type byte is always in range
			if (voff_q == 16'd0 && type_q == ST_LINK_TYPE) begin
				fld_v             = 1'b1;
				fld.field_code    = FC_LINK_TYPE;
				fld.field_value   = {24'h000000, b};
				seen_type_n       = 1'b1;
			end
			if (voff_q[1:0] == 2'b11) begin
				if (voff_inc <= {1'b0, len_q}) begin
					fld.field_value = shift_n;
					if (type_q == ST_UNRSV_BW) begin
						if (wc_q < 4'(UNRSV_WORDS)) begin
							fld_v          = 1'b1;
							fld.field_code = FC_UNRSV_BW;
							fld.slot_index = 3'(wc_q);
						end
					end else if (wc_q == 4'd0) begin
						unique case (type_q)
							ST_LINK_ID: begin
								fld_v          = 1'b1;
								fld.field_code = FC_LINK_ID;
								seen_id_n      = 1'b1;
							end
							ST_LOCAL_ADDR: begin
								if (lfill_q < FILL_W'(ADDR_SLOTS)) begin
									fld_v          = 1'b1;
									fld.field_code = FC_LOCAL_ADDR;
									fld.slot_index = 3'(lfill_q);
									if (shift_n != 32'd0) lfill_n = lfill_q + FILL_W'(1);
								end
							end
							ST_REMOTE_ADDR: begin
								if (rfill_q < FILL_W'(ADDR_SLOTS)) begin
									fld_v          = 1'b1;
									fld.field_code = FC_REMOTE_ADDR;
									fld.slot_index = 3'(rfill_q);
									if (shift_n != 32'd0) rfill_n = rfill_q + FILL_W'(1);
								end
							end
							ST_METRIC: begin
								fld_v          = 1'b1;
								fld.field_code = FC_METRIC;
							end
							ST_MAX_BW: begin
								fld_v          = 1'b1;
								fld.field_code = FC_MAX_BW;
							end
							ST_MAX_RSV_BW: begin
								fld_v          = 1'b1;
								fld.field_code = FC_MAX_RSV_BW;
							end
							ST_ADMIN_GROUP: begin
								fld_v          = 1'b1;
								fld.field_code = FC_ADMIN_GROUP;
							end
							default: ;
						endcase
					end
				end
				if (wc_q != 4'hF) wc_n = wc_q + 4'd1;
			end
			voff_n = voff_q + 16'd1;
			if (voff_inc >= padded) begin
				in_value_n = 1'b0;
				hdr_pos_n  = 2'd0;
			end
		end

		end_res             = '0;
		end_res.field_code  = FC_END;
		end_res.parse_ok    = seen_type_n & seen_id_n;
		end_res.last_result = 1'b1;

		push = '0;
		if (in_byte.last_byte) begin
			if (fld_v) begin
				push.push_a = acc;
				push.res_a  = fld;
				push.push_b = acc;
				push.res_b  = end_res;
			end else begin
				push.push_a = acc;
				push.res_a  = end_res;
			end
			hdr_pos_n   = 2'd0;
			in_value_n  = 1'b0;
			voff_n      = '0;
			type_n      = '0;
			len_n       = '0;
			shift_n     = '0;
			wc_n        = '0;
			lfill_n     = '0;
			rfill_n     = '0;
			seen_type_n = 1'b0;
			seen_id_n   = 1'b0;
		end else begin
			push.push_a = acc & fld_v;
			push.res_a  = fld;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q   <= '0;
			in_value_q  <= 1'b0;
			voff_q      <= '0;
			type_q      <= '0;
			len_q       <= '0;
			shift_q     <= '0;
			wc_q        <= '0;
			lfill_q     <= '0;
			rfill_q     <= '0;
			seen_type_q <= 1'b0;
			seen_id_q   <= 1'b0;
		end else if (acc) begin
			hdr_pos_q   <= hdr_pos_n;
			in_value_q  <= in_value_n;
			voff_q      <= voff_n;
			type_q      <= type_n;
			len_q       <= len_n;
			shift_q     <= shift_n;
			wc_q        <= wc_n;
			lfill_q     <= lfill_n;
			rfill_q     <= rfill_n;
			seen_type_q <= seen_type_n;
			seen_id_q   <= seen_id_n;
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_byte.last_byte |=> !in_value_q && hdr_pos_q == 2'd0
			&& !seen_type_q && !seen_id_q && lfill_q == '0 && rfill_q == '0)
		else $error("state not cleared after last byte");

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.push_b |-> push.push_a && push.res_b.last_result && !push.res_a.last_result)
		else $error("second result without a field result ahead of it");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lfill_q <= FILL_W'(ADDR_SLOTS) && rfill_q <= FILL_W'(ADDR_SLOTS))
		else $error("address fill beyond slot count");

endmodule

// ===== rtl/tlsp_fifo.sv =====
module tlsp_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  tlsp_pkg::push_t push,
	input  logic            pop,
	output logic            space,
	output logic            nonempty,
	output tlsp_pkg::res_t  head
);
	import tlsp_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	res_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] wr_ptr_b;
	logic [1:0]       n_push;

	assign wr_ptr_b = wr_ptr_q + PTR_W'(1);
	assign n_push   = {1'b0, push.push_a} + {1'b0, push.push_b};
	assign space    = cnt_q <= CNT_W'(DEPTH - 2);
	assign nonempty = cnt_q != '0;
	assign head     = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.push_a) mem[wr_ptr_q] <= push.res_a;
		if (push.push_b) mem[wr_ptr_b] <= push.res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			cnt_q <= cnt_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("result queue overflow");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!space |-> !push.push_a && !push.push_b)
		else $error("push while queue has no room for two");

endmodule

// ===== rtl/te_link_subtlv_parser.sv =====
// Byte-serial parser for the sub-TLVs of a traffic engineering Link TLV body.
// One byte is taken per cycle; each byte updates the parser state in the same
// cycle and may queue up to two results (a decoded field, then the end status
// on the byte marked last). Results leave through a four-entry queue, one per
// cycle while the receiver is ready; input ready drops only while that queue
// holds more than two results, so the byte rate is one per cycle whenever the
// result side keeps up. ADDR_SLOTS sets how many local and remote address
// slots fill (a zero address takes none); addresses beyond them are dropped.
module te_link_subtlv_parser #(
	parameter int ADDR_SLOTS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tlsp_stream_if.sink          bytes,
	tlsp_stream_if.source        results
);
	import tlsp_pkg::*;

	logic  acc;
	logic  pop;
	logic  space;
	logic  nonempty;
	push_t push;
	res_t  head;
	byte_t in_byte;

	assign in_byte       = bytes.payload;
	assign bytes.ready   = space;
	assign acc           = bytes.valid && space;
	assign results.valid = nonempty;
	assign results.payload = head;
	assign pop           = nonempty && results.ready;

	tlsp_core #(.ADDR_SLOTS(ADDR_SLOTS)) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.in_byte (in_byte),
		.push    (push)
	);

	tlsp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.space    (space),
		.nonempty (nonempty),
		.head     (head)
	);

endmodule
